// ----- src/bcc_pkg.sv -----
package bcc_pkg;

    // Mode codes as seen on the result word
    localparam logic [1:0] MODE_CHARGE    = 2'd0;
    localparam logic [1:0] MODE_DISCHARGE = 2'd1;
    localparam logic [1:0] MODE_MEASURE   = 2'd2;

    // Register indexes (byte address 4*index)
    localparam logic [1:0] REG_TICKS_PER_STEP   = 2'd0;
    localparam logic [1:0] REG_CHARGE_PHASES    = 2'd1;
    localparam logic [1:0] REG_DISCHARGE_PHASES = 2'd2;
    localparam logic [1:0] REG_AVG_LIMIT        = 2'd3;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int LIMIT_W     = 10;
    localparam int AVG_W       = 10;
    localparam int OUT_DATA_W  = 24;

    // Reset values of the registers
    localparam logic [7:0]         RST_TICKS_PER_STEP   = 8'd4;
    localparam logic [7:0]         RST_CHARGE_PHASES    = 8'd10;
    localparam logic [7:0]         RST_DISCHARGE_PHASES = 8'd10;
    localparam logic [LIMIT_W-1:0] RST_AVG_LIMIT        = 10'd343;

    // Steps in one phase
    localparam logic [4:0] STEPS_PER_PHASE = 5'd16;

    // Last phase of the six-phase flash cycle
    localparam logic [2:0] FLASH_LAST = 3'd5;
    localparam logic [2:0] FLASH_ON   = 3'd0;
    localparam logic [2:0] FLASH_OFF  = 3'd1;

    typedef struct packed {
        logic [7:0]         ticks_per_step;
        logic [7:0]         charge_phases;
        logic [7:0]         discharge_phases;
        logic [LIMIT_W-1:0] avg_limit;
    } t_cfg;

    typedef struct packed {
        logic [AVG_W-1:0] average_voltage;
        logic             average_valid;
        logic             active_lamp;
        logic [2:0]       mode_lamps;
        logic [1:0]       mode;
        logic             relay_on;
    } t_result;

    // Lamp bit belonging to a mode; the unused code has no lamp
    function automatic logic [2:0] mode_lamp(input logic [1:0] mode);
        logic [2:0] lamp;
        case (mode)
            MODE_CHARGE:    lamp = 3'b001;
            MODE_DISCHARGE: lamp = 3'b010;
            MODE_MEASURE:   lamp = 3'b100;
            default:        lamp = 3'b000;
        endcase
        return lamp;
    endfunction

endpackage

// ----- src/battery_cycle_controller.sv -----
// Battery cycle controller: one result word per timer-overflow input word.
// An accepted input word is held in the input register, then passes the
// combinational step logic into the result register.
// Throughput: one word per cycle, limited only by the output handshake.
// Reset: synchronous, active low; registers and controller state return to
// their start-up values (discharge mode, relay on).
module battery_cycle_controller #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [SAMPLE_BITS-1:0] adc_sample, rest zero
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] relay_on, [2:1] mode, [5:3] mode_lamps, [6] active_lamp,
    // [7] average_valid, [17:8] average_voltage, [23:18] zero
    output logic [bcc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bcc_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [bcc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [bcc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import bcc_pkg::*;

    t_cfg                   cfg;
    t_result                core_res;
    t_result                r_out;
    logic                   r_out_valid;
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic                   advance;
    logic                   in_accept;

    bcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: the input word moves on when the result register is free
    assign advance       = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | advance;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    bcc_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_sample (r_in_sample),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.average_voltage, r_out.average_valid,
                            r_out.active_lamp, r_out.mode_lamps, r_out.mode,
                            r_out.relay_on};

endmodule

// ----- src/bcc_regs.sv -----
module bcc_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bcc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bcc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bcc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output bcc_pkg::t_cfg                      o_cfg
);
    import bcc_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_step   <= RST_TICKS_PER_STEP;
            r_cfg.charge_phases    <= RST_CHARGE_PHASES;
            r_cfg.discharge_phases <= RST_DISCHARGE_PHASES;
            r_cfg.avg_limit        <= RST_AVG_LIMIT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TICKS_PER_STEP:   r_cfg.ticks_per_step   <= pwdata[7:0];
                REG_CHARGE_PHASES:    r_cfg.charge_phases    <= pwdata[7:0];
                REG_DISCHARGE_PHASES: r_cfg.discharge_phases <= pwdata[7:0];
                REG_AVG_LIMIT:        r_cfg.avg_limit        <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        case (reg_idx)
            REG_TICKS_PER_STEP:   prdata = {24'd0, r_cfg.ticks_per_step};
            REG_CHARGE_PHASES:    prdata = {24'd0, r_cfg.charge_phases};
            REG_DISCHARGE_PHASES: prdata = {24'd0, r_cfg.discharge_phases};
            REG_AVG_LIMIT:        prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, r_cfg.avg_limit};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/bcc_core.sv -----
module bcc_core #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  bcc_pkg::t_cfg          i_cfg,
    output bcc_pkg::t_result       o_result
);
    import bcc_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + 4;
    localparam int CMP_W = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;

    logic [7:0]       r_ovf,   n_ovf;
    logic [4:0]       r_step,  n_step;
    logic [7:0]       r_phase, n_phase;
    logic [1:0]       r_mode,  n_mode;
    logic [SUM_W-1:0] r_sum,   n_sum;
    logic             r_relay, n_relay;
    logic [2:0]       r_lamps, n_lamps;
    logic             r_ind,   n_ind;
    logic [2:0]       r_flash, n_flash;

    logic             avg_valid;
    logic [CMP_W-1:0] avg;
    logic [2:0]       lamp;

    // Next state for one timer overflow
    always_comb begin
        n_ovf     = r_ovf + 8'd1;
        n_step    = r_step;
        n_phase   = r_phase;
        n_mode    = r_mode;
        n_sum     = r_sum;
        n_relay   = r_relay;
        n_lamps   = r_lamps;
        n_ind     = r_ind;
        n_flash   = r_flash;
        avg_valid = 1'b0;
        avg       = '0;
        lamp      = 3'b000;

        if (n_ovf == i_cfg.ticks_per_step) begin
            n_ovf  = 8'd0;
            n_step = r_step + 5'd1;
            if (r_mode == MODE_MEASURE) begin
                n_sum = r_sum + SUM_W'(i_sample);
            end

            // phase end
            if (n_step == STEPS_PER_PHASE) begin
                n_step = 5'd0;
                case (r_mode)
                    MODE_CHARGE: begin
                        n_phase = r_phase + 8'd1;
                        if (n_phase == i_cfg.charge_phases) begin
                            n_relay = 1'b1;
                            n_mode  = MODE_MEASURE;
                            n_lamps = mode_lamp(MODE_MEASURE);
                            n_ind   = 1'b0;
                            n_sum   = '0;
                        end
                    end
                    MODE_DISCHARGE: begin
                        n_phase = r_phase + 8'd1;
                        if (n_phase == i_cfg.discharge_phases) begin
                            n_mode  = MODE_MEASURE;
                            n_lamps = mode_lamp(MODE_MEASURE);
                            n_ind   = 1'b0;
                            n_sum   = '0;
                        end
                    end
                    MODE_MEASURE: begin
                        avg       = CMP_W'(n_sum[SUM_W-1:4]);
                        n_sum     = SUM_W'(n_sum[SUM_W-1:4]);
                        avg_valid = 1'b1;
                        n_ind     = 1'b1;
                        n_phase   = 8'd0;
                        if (avg > CMP_W'(i_cfg.avg_limit)) begin
                            n_relay = 1'b1;
                            n_mode  = MODE_DISCHARGE;
                        end else begin
                            n_relay = 1'b0;
                            n_mode  = MODE_CHARGE;
                        end
                        n_lamps = mode_lamp(n_mode);
                    end
                    default: ;
                endcase
            end

            // flash cycle on the lamp of the current mode
            lamp = mode_lamp(n_mode);
            case (r_flash)
                FLASH_ON: begin
                    n_lamps = n_lamps | lamp;
                    n_flash = 3'd1;
                end
                FLASH_OFF: begin
                    n_lamps = n_lamps & ~lamp;
                    n_flash = 3'd2;
                end
                FLASH_LAST: n_flash = 3'd0;
                default:    n_flash = r_flash + 3'd1;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf   <= 8'd0;
            r_step  <= 5'd0;
            r_phase <= 8'd0;
            r_mode  <= MODE_DISCHARGE;
            r_sum   <= '0;
            r_relay <= 1'b1;
            r_lamps <= mode_lamp(MODE_DISCHARGE);
            r_ind   <= 1'b1;
            r_flash <= 3'd0;
        end else if (i_step) begin
            r_ovf   <= n_ovf;
            r_step  <= n_step;
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_sum   <= n_sum;
            r_relay <= n_relay;
            r_lamps <= n_lamps;
            r_ind   <= n_ind;
            r_flash <= n_flash;
        end
    end

    // Result word for this overflow
    always_comb begin
        o_result.relay_on        = n_relay;
        o_result.mode            = n_mode;
        o_result.mode_lamps      = n_lamps;
        o_result.active_lamp     = n_ind;
        o_result.average_valid   = avg_valid;
        o_result.average_voltage = avg[AVG_W-1:0];
    end

endmodule
